// ===== rtl/tli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int DATA_W          = 32;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 3;
    localparam int TABLE_DEPTH_DEF = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INTERP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OOB    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ===== rtl/tli_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_divider
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits DATA_W bits.
// ----------------------------------------------------------------------------
module tli_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tli_pkg::PROD_W-1:0]    i_dividend,
    input  logic [tli_pkg::DATA_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [tli_pkg::DATA_W-1:0]    o_quotient
);
    import tli_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_rem, r_quo, r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;

    logic [DATA_W:0]   w_rem_sh;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:DATA_W];
            r_quo <= i_dividend[DATA_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DATA_W'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/table_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear lookup table over up to TABLE_DEPTH signed Q16.16 pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (clear,
//   load pair, query), tdata the x value (low word) and the y value (high
//   word). Every request gives exactly one answer on the m_axis channel:
//   tdata is the y value, tuser the status code.
//   Clear, load and the reserved command finish in the accept cycle; their
//   answer is valid on the next cycle.
//   A query scans the stored pairs through the memory read port, one entry
//   per cycle, then decides. An exact match or out of bounds answer passes
//   from the scan through S_FIN into the output register. An interpolation
//   adds a difference stage, a 32x32 multiply and the 32-step divider.
//   Scan length and the divider set the rate.
//   One request is in flight at a time; s_axis_tready is high only while
//   idle and the output register is empty or being drained.
//   A stalled receiver holds the answer in the output register; a finished
//   query waits in its last state until the register frees up.
//   Reset empties the table and drops any pending answer. Table contents
//   need no clearing: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [2*tli_pkg::DATA_W-1:0]    s_axis_tdata,   // point_x, point_y
    input  logic [tli_pkg::CMD_W-1:0]       s_axis_tuser,   // command
    // answer channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tli_pkg::DATA_W-1:0]      m_axis_tdata,   // result_value
    output logic [tli_pkg::STATUS_W-1:0]    m_axis_tuser    // status
);
    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic signed [DATA_W+1:0] SAT_MAX = {3'b000, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W+1:0] SAT_MIN = {3'b111, {(DATA_W-1){1'b0}}};

    // ---------------- table memories ----------------
    logic [DATA_W-1:0] r_mem_x [TABLE_DEPTH];
    logic [DATA_W-1:0] r_mem_y [TABLE_DEPTH];
    logic [DATA_W-1:0] r_rd_x, r_rd_y;

    // ---------------- control and working registers ----------------
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_rd_valid;
    logic [DATA_W-1:0] r_qx, n_qx;
    logic              r_has_lo, n_has_lo, r_has_hi, n_has_hi, r_match, n_match;
    logic [DATA_W-1:0] r_lo_x, n_lo_x, r_lo_y, n_lo_y;
    logic [DATA_W-1:0] r_hi_x, n_hi_x, r_hi_y, n_hi_y;
    logic [DATA_W-1:0] r_match_y, n_match_y;
    logic [DATA_W-1:0] r_dq, n_dq, r_dx, n_dx, r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [DATA_W-1:0]   r_res_value, n_res_value;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // ---------------- combinational helpers ----------------
    logic              w_accept, w_out_free, w_full;
    logic [CMD_W-1:0]  w_cmd;
    logic [DATA_W-1:0] w_px, w_py;
    logic              w_mem_we, w_rd_en, w_scan_done;
    logic              w_eq, w_lt;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start, w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic signed [DATA_W+1:0] w_sum;

    assign w_cmd      = s_axis_tuser;
    assign w_px       = s_axis_tdata[DATA_W-1:0];
    assign w_py       = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_full     = (r_count == CW'(TABLE_DEPTH));

    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mem_we      = w_accept && (w_cmd == CMD_LOAD) && !w_full;

    // scan: address issued while index below fill count, data on the next cycle
    assign w_rd_en     = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_scan_done = (r_state == S_SCAN) && !w_rd_en && !r_rd_valid;

    assign w_eq = (r_rd_x == r_qx);
    assign w_lt = ($signed(r_rd_x) < $signed(r_qx));

    // dq and magnitude of dy both stay below 2^32, so the product fits 64 bits
    assign w_prod      = PROD_W'(r_dq) * PROD_W'(r_mag);
    assign w_div_start = (r_state == S_MUL);

    // fa +/- t; t lies below |fc - fa|, the clamp is a safety net
    assign w_sum = r_neg
        ? $signed({{2{r_lo_y[DATA_W-1]}}, r_lo_y}) - $signed({2'b00, w_quot})
        : $signed({{2{r_lo_y[DATA_W-1]}}, r_lo_y}) + $signed({2'b00, w_quot});

    tli_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_dx),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem_x[r_count[AW-1:0]] <= w_px;
            r_mem_y[r_count[AW-1:0]] <= w_py;
        end
        if (w_rd_en) begin
            r_rd_x <= r_mem_x[r_idx[AW-1:0]];
            r_rd_y <= r_mem_y[r_idx[AW-1:0]];
        end
    end

    // ---------------- next state and datapath ----------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_qx         = r_qx;
        n_has_lo     = r_has_lo;
        n_has_hi     = r_has_hi;
        n_match      = r_match;
        n_lo_x       = r_lo_x;
        n_lo_y       = r_lo_y;
        n_hi_x       = r_hi_x;
        n_hi_y       = r_hi_y;
        n_match_y    = r_match_y;
        n_dq         = r_dq;
        n_dx         = r_dx;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_CLEAR: begin
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = ST_DONE;
                        end
                        CMD_LOAD: begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_count      = r_count + 1'b1;
                                n_out_status = ST_DONE;
                            end
                        end
                        CMD_QUERY: begin
                            n_qx     = w_px;
                            n_idx    = '0;
                            n_has_lo = 1'b0;
                            n_has_hi = 1'b0;
                            n_match  = 1'b0;
                            n_state  = S_SCAN;
                        end
                        CMD_NOP: begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_valid) begin
                    if (w_eq) begin
                        n_match   = 1'b1;
                        n_match_y = r_rd_y;
                    end else if (w_lt) begin
                        // strict compare keeps the first-loaded duplicate
                        if (!r_has_lo || ($signed(r_rd_x) > $signed(r_lo_x))) begin
                            n_has_lo = 1'b1;
                            n_lo_x   = r_rd_x;
                            n_lo_y   = r_rd_y;
                        end
                    end else begin
                        if (!r_has_hi || ($signed(r_rd_x) < $signed(r_hi_x))) begin
                            n_has_hi = 1'b1;
                            n_hi_x   = r_rd_x;
                            n_hi_y   = r_rd_y;
                        end
                    end
                end
                if (w_scan_done) begin
                    // below the minimum means no lower neighbor and no match,
                    // likewise above the maximum
                    if (r_match) begin
                        n_res_value  = r_match_y;
                        n_res_status = ST_MATCH;
                        n_state      = S_FIN;
                    end else if (r_has_lo && r_has_hi) begin
                        n_state = S_PREP;
                    end else begin
                        n_res_value  = '0;
                        n_res_status = ST_OOB;
                        n_state      = S_FIN;
                    end
                end
            end
            S_PREP: begin
                n_dq    = DATA_W'($signed({r_qx[DATA_W-1], r_qx})
                                  - $signed({r_lo_x[DATA_W-1], r_lo_x}));
                n_dx    = DATA_W'($signed({r_hi_x[DATA_W-1], r_hi_x})
                                  - $signed({r_lo_x[DATA_W-1], r_lo_x}));
                n_neg   = ($signed(r_hi_y) < $signed(r_lo_y));
                n_mag   = ($signed(r_hi_y) < $signed(r_lo_y)) ? (r_lo_y - r_hi_y)
                                                               : (r_hi_y - r_lo_y);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_sum > SAT_MAX) begin
                        n_res_value = SAT_MAX[DATA_W-1:0];
                    end else if (w_sum < SAT_MIN) begin
                        n_res_value = SAT_MIN[DATA_W-1:0];
                    end else begin
                        n_res_value = w_sum[DATA_W-1:0];
                    end
                    n_res_status = ST_INTERP;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_valid  <= w_rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx         <= n_qx;
        r_has_lo     <= n_has_lo;
        r_has_hi     <= n_has_hi;
        r_match      <= n_match;
        r_lo_x       <= n_lo_x;
        r_lo_y       <= n_lo_y;
        r_hi_x       <= n_hi_x;
        r_hi_y       <= n_hi_y;
        r_match_y    <= n_match_y;
        r_dq         <= n_dq;
        r_dx         <= n_dx;
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_load_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_LOAD) && !w_full)
        |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("load did not advance fill count");

    a_query_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_QUERY)) |=> (r_state == S_SCAN))
        else $error("query did not start a scan");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

endmodule
